@@ hdl/unit_vector_slerp_defines.svh @@
// Assertion macros for the unit_vector_slerp block.
// Used by modules that have clk and rst_n in scope; no other dependencies.
`ifndef UNIT_VECTOR_SLERP_DEFINES_SVH
`define UNIT_VECTOR_SLERP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UVS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("unit_vector_slerp: check failed");

// Next-cycle implication, checked outside reset.
`define UVS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("unit_vector_slerp: check failed");

`endif

@@ hdl/uvs_pkg.sv @@
// Shared types and constants for unit_vector_slerp.
// No dependencies.
`default_nettype none

package uvs_pkg;

    localparam int CW     = 36;   // CORDIC datapath width (x, y and angle)
    localparam int RAD_W  = 31;   // radicand width for the root
    localparam int ROOT_W = 16;   // root width
    localparam int THR_W  = 15;

    localparam logic signed [CW-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [CW-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam int INVK_LIMIT = 652032874;
    localparam int INVK_THIRD = INVK_LIMIT / 3;
    localparam int NEAR_ZERO  = 26844;
    localparam logic [16:0] BLEND_ONE = 17'd32768;
    localparam logic [THR_W-1:0] THR_RESET = 15'd32751;

    // lane modes of a CORDIC cell
    localparam logic MODE_VEC = 1'b0;
    localparam logic MODE_ROT = 1'b1;

    typedef logic [THR_W-1:0] thr_t;

    typedef struct packed {
        logic signed [15:0] from_x;
        logic signed [15:0] from_y;
        logic signed [15:0] from_z;
        logic signed [15:0] to_x;
        logic signed [15:0] to_y;
        logic signed [15:0] to_z;
        logic        [15:0] blend;
    } in_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
    } out_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_t;

    // atan(2^-i) in Q.30, truncated
    function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
        logic signed [CW-1:0] r;
        case (i)
            0:  r = 36'sd843314856;
            1:  r = 36'sd497837829;
            2:  r = 36'sd263043836;
            3:  r = 36'sd133525158;
            4:  r = 36'sd67021686;
            5:  r = 36'sd33543515;
            6:  r = 36'sd16769706;
            7:  r = 36'sd8386389;
            8:  r = 36'sd4194282;
            9:  r = 36'sd2097149;
            10: r = 36'sd1048575;
            11: r = 36'sd524287;
            12: r = 36'sd262143;
            13: r = 36'sd131071;
            14: r = 36'sd65535;
            15: r = 36'sd32767;
            16: r = 36'sd16383;
            17: r = 36'sd8191;
            18: r = 36'sd4095;
            19: r = 36'sd2047;
            20: r = 36'sd1023;
            21: r = 36'sd511;
            22: r = 36'sd255;
            23: r = 36'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/uvs_sqrt_cell.sv @@
// One bit of the digit-by-digit integer square root, registered.
// Depends on uvs_pkg.
`default_nettype none

module uvs_sqrt_cell #(
    parameter int BIT = 15,
    parameter int SW  = 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      vld_in,
    input  wire logic [uvs_pkg::RAD_W-1:0]  rem_in,
    input  wire logic [uvs_pkg::ROOT_W-1:0] root_in,
    input  wire logic [SW-1:0]             side_in,
    output logic                           vld_out,
    output logic [uvs_pkg::RAD_W-1:0]      rem_out,
    output logic [uvs_pkg::ROOT_W-1:0]     root_out,
    output logic [SW-1:0]                  side_out
);
    import uvs_pkg::*;

    logic                 vld_reg;
    logic [RAD_W-1:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic [SW-1:0]        side_reg;
    logic [RAD_W+1:0]     trial;

    // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
    always_comb
    begin
        trial     = ((RAD_W+2)'(root_in) << (BIT + 1)) + ((RAD_W+2)'(1) << (2 * BIT));
        rem_next  = rem_in;
        root_next = root_in;
        if (trial <= (RAD_W+2)'(rem_in))
        begin
            rem_next  = RAD_W'((RAD_W+2)'(rem_in) - trial);
            root_next = root_in | (ROOT_W'(1) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

@@ hdl/uvs_cordic_cell.sv @@
// One CORDIC micro-rotation for two lanes side by side, registered.
// Depends on uvs_pkg (cordic_t, atan table, lane modes).
`default_nettype none

module uvs_cordic_cell #(
    parameter int   STAGE  = 0,
    parameter logic MODE_A = uvs_pkg::MODE_VEC,
    parameter logic MODE_B = uvs_pkg::MODE_VEC,
    parameter int   SW     = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             vld_in,
    input  wire uvs_pkg::cordic_t a_in,
    input  wire uvs_pkg::cordic_t b_in,
    input  wire logic [SW-1:0]    side_in,
    output logic                  vld_out,
    output uvs_pkg::cordic_t      a_out,
    output uvs_pkg::cordic_t      b_out,
    output logic [SW-1:0]         side_out
);
    import uvs_pkg::*;

    // vectoring drives y to zero, rotation drives z to zero
    function automatic cordic_t step(input cordic_t c, input logic mode);
        cordic_t              r;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] at;
        logic                 cw;
        dx = c.y >>> STAGE;
        dy = c.x >>> STAGE;
        at = atan_q30(STAGE);
        cw = (mode == MODE_ROT) ? !c.z[CW-1] : c.y[CW-1];
        if (cw)
        begin
            r.x = c.x - dx;
            r.y = c.y + dy;
            r.z = c.z - at;
        end
        else
        begin
            r.x = c.x + dx;
            r.y = c.y - dy;
            r.z = c.z + at;
        end
        return r;
    endfunction

    logic          vld_reg;
    cordic_t       a_reg;
    cordic_t       b_reg;
    logic [SW-1:0] side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= step(a_in, MODE_A);
            b_reg    <= step(b_in, MODE_B);
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign a_out    = a_reg;
    assign b_out    = b_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

@@ hdl/uvs_cordic_row.sv @@
// A row of N CORDIC cells, stage 0 first; two lanes plus side data.
// Depends on uvs_pkg and uvs_cordic_cell.
`default_nettype none

module uvs_cordic_row #(
    parameter int   N      = 16,
    parameter logic MODE_A = uvs_pkg::MODE_VEC,
    parameter logic MODE_B = uvs_pkg::MODE_VEC,
    parameter int   SW     = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             vld_in,
    input  wire uvs_pkg::cordic_t a_in,
    input  wire uvs_pkg::cordic_t b_in,
    input  wire logic [SW-1:0]    side_in,
    output logic                  vld_out,
    output uvs_pkg::cordic_t      a_out,
    output uvs_pkg::cordic_t      b_out,
    output logic [SW-1:0]         side_out
);
    import uvs_pkg::*;

    logic          vld_w  [N+1];
    cordic_t       a_w    [N+1];
    cordic_t       b_w    [N+1];
    logic [SW-1:0] side_w [N+1];

    assign vld_w[0]  = vld_in;
    assign a_w[0]    = a_in;
    assign b_w[0]    = b_in;
    assign side_w[0] = side_in;

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        uvs_cordic_cell #(
            .STAGE  (g),
            .MODE_A (MODE_A),
            .MODE_B (MODE_B),
            .SW     (SW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (vld_w[g]),
            .a_in     (a_w[g]),
            .b_in     (b_w[g]),
            .side_in  (side_w[g]),
            .vld_out  (vld_w[g+1]),
            .a_out    (a_w[g+1]),
            .b_out    (b_w[g+1]),
            .side_out (side_w[g+1])
        );
    end

    assign vld_out  = vld_w[N];
    assign a_out    = a_w[N];
    assign b_out    = b_w[N];
    assign side_out = side_w[N];

endmodule

`default_nettype wire

@@ hdl/unit_vector_slerp.sv @@
// Top level of unit_vector_slerp: fixed-point slerp of two unit vectors.
// Depends on uvs_pkg, uvs_sqrt_cell, uvs_cordic_row, unit_vector_slerp_defines.svh.
//
//   channel | signals                          | beat
//   --------+----------------------------------+--------------------------------
//   in      | in_valid, in_ready, in_data      | from/to vectors and blend
//   out     | out_valid, out_ready, out_data   | interpolated vector, Q1.15
//   cfg     | cfg_valid, cfg_ready, cfg_data   | parallel_threshold, 15 bits
//
// One beat in and one beat out per cycle when out_ready stays high.
// The pipeline is four front stages, sixteen root cells, three rows of
// CORDIC_STAGES cells and five single stages.
// Every stage advances together; when the output register is full and
// out_ready is low the whole chain holds and in_ready drops.
// Reset clears valid bits and loads the threshold with 32751; cfg_ready is
// always high.
`default_nettype none

module unit_vector_slerp #(
    parameter int CORDIC_STAGES = 16   // 8..24
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire uvs_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output uvs_pkg::out_t      out_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire uvs_pkg::thr_t cfg_data
);
    import uvs_pkg::*;

`include "unit_vector_slerp_defines.svh"

    // inverse CORDIC gain for the chosen stage count, Q.30
    localparam int INVK_I = INVK_LIMIT + (INVK_THIRD >> (2 * CORDIC_STAGES - 1));
    localparam logic [30:0]          INVK = 31'(INVK_I);
    localparam logic signed [CW-1:0] K36  = CW'(INVK_I);

    // side data carried through the cell rows
    typedef struct packed {
        logic signed [CW-1:0] v0;
        logic signed [CW-1:0] v1;
        logic signed [CW-1:0] v2;
        logic signed [15:0]   f0;
        logic signed [15:0]   f1;
        logic signed [15:0]   f2;
        logic [16:0]          a;
        logic signed [15:0]   d;
        logic                 lin;
    } sq_side_t;

    typedef struct packed {
        logic signed [CW-1:0] v2;
        logic signed [15:0]   f0;
        logic signed [15:0]   f1;
        logic signed [15:0]   f2;
        logic [16:0]          a;
        logic                 lin;
    } ra_side_t;

    typedef struct packed {
        logic signed [15:0]   f0;
        logic signed [15:0]   f1;
        logic signed [15:0]   f2;
        logic signed [CW-1:0] phi;
        logic                 lin;
    } rb_side_t;

    typedef struct packed {
        logic signed [15:0] f0;
        logic signed [15:0] f1;
        logic signed [15:0] f2;
        logic signed [31:0] c;
        logic signed [31:0] s;
        logic               nz;
        logic               lin;
    } rc_side_t;

    localparam int SQ_SW = $bits(sq_side_t);
    localparam int RA_SW = $bits(ra_side_t);
    localparam int RB_SW = $bits(rb_side_t);
    localparam int RC_SW = $bits(rc_side_t);

    // vectoring pre-rotation: fold the left half plane onto the right
    function automatic cordic_t vec_prep(input logic signed [CW-1:0] x,
                                         input logic signed [CW-1:0] y);
        cordic_t r;
        r.x = x;
        r.y = y;
        r.z = '0;
        if (x[CW-1])
        begin
            r.x = -x;
            r.y = -y;
            r.z = y[CW-1] ? -Q30_PI : Q30_PI;
        end
        return r;
    endfunction

    // rotation pre-rotation by a quarter turn beyond +-pi/2
    function automatic cordic_t rot_prep(input logic signed [CW-1:0] z);
        cordic_t r;
        r.x = K36;
        r.y = '0;
        r.z = z;
        if (z > Q30_HALF_PI)
        begin
            r.x = '0;
            r.y = K36;
            r.z = z - Q30_HALF_PI;
        end
        else if (z < -Q30_HALF_PI)
        begin
            r.x = '0;
            r.y = -K36;
            r.z = z + Q30_HALF_PI;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767)
            r = 16'sh7fff;
        else if (v < -20'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    logic en;
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // ---------------- threshold register ----------------
    thr_t thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // ---------------- stage 0: capture, clamp blend ----------------
    logic               s0_vld_reg;
    logic signed [15:0] s0_f_reg [3];
    logic signed [15:0] s0_t_reg [3];
    logic [16:0]        s0_a_reg, s0_a_next;

    assign s0_a_next = (in_data.blend > 16'd32768) ? BLEND_ONE : {1'b0, in_data.blend};

    // ---------------- stage 1: component products ----------------
    logic               s1_vld_reg;
    logic signed [31:0] s1_p_reg [3];
    logic signed [15:0] s1_f_reg [3];
    logic signed [15:0] s1_t_reg [3];
    logic [16:0]        s1_a_reg;

    // ---------------- stage 2: dot and branch ----------------
    logic               s2_vld_reg;
    logic signed [18:0] s2_d_reg, s2_d_next;
    logic               s2_lin_reg, s2_lin_next;
    logic signed [15:0] s2_f_reg [3];
    logic signed [15:0] s2_t_reg [3];
    logic [16:0]        s2_a_reg;
    logic signed [33:0] dot_sum;
    logic signed [19:0] thr_s;

    always_comb
    begin
        dot_sum     = 34'(s1_p_reg[0]) + 34'(s1_p_reg[1]) + 34'(s1_p_reg[2]);
        s2_d_next   = 19'((dot_sum + 34'sd16384) >>> 15);
        thr_s       = $signed({5'b0, thr_reg});
        s2_lin_next = (20'(s2_d_next) > thr_s) || (20'(s2_d_next) < -thr_s);
    end

    // ---------------- stage 3: vector to normalize, radicand ----------------
    logic               s3_vld_reg;
    logic signed [CW-1:0] s3_v_next [3];
    logic [RAD_W-1:0]   s3_rad_next;
    sq_side_t           s3_side_reg;
    logic [RAD_W-1:0]   s3_rad_reg;
    logic signed [37:0] dd;
    logic signed [16:0] mul_a [3];
    logic signed [18:0] mul_b;
    logic signed [15:0] base [3];

    // linear: f*2^15 + (t - f)*a ; slerp: t*2^15 - f*d
    always_comb
    begin
        mul_b = s2_lin_reg ? $signed({2'b0, s2_a_reg}) : s2_d_reg;
        for (int i = 0; i < 3; i++)
        begin
            mul_a[i] = s2_lin_reg ? (17'(s2_t_reg[i]) - 17'(s2_f_reg[i]))
                                  : -17'(s2_f_reg[i]);
            base[i]  = s2_lin_reg ? s2_f_reg[i] : s2_t_reg[i];
            s3_v_next[i] = (CW'(base[i]) <<< 15) + CW'(mul_a[i] * mul_b);
        end
        dd          = 38'(s2_d_reg) * 38'(s2_d_reg);
        s3_rad_next = s2_lin_reg ? '0 : RAD_W'((38'sd1 <<< 30) - dd);
    end

    // ---------------- square root cells ----------------
    logic             sq_vld  [ROOT_W+1];
    logic [RAD_W-1:0] sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root [ROOT_W+1];
    logic [SQ_SW-1:0] sq_side [ROOT_W+1];

    assign sq_vld[0]  = s3_vld_reg;
    assign sq_rem[0]  = s3_rad_reg;
    assign sq_root[0] = '0;
    assign sq_side[0] = s3_side_reg;

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_sqrt
        uvs_sqrt_cell #(
            .BIT (ROOT_W - 1 - g),
            .SW  (SQ_SW)
        ) u_sqrt (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (sq_vld[g]),
            .rem_in   (sq_rem[g]),
            .root_in  (sq_root[g]),
            .side_in  (sq_side[g]),
            .vld_out  (sq_vld[g+1]),
            .rem_out  (sq_rem[g+1]),
            .root_out (sq_root[g+1]),
            .side_out (sq_side[g+1])
        );
    end

    // ---------------- row A: acos angle and first normalize vectoring ----------------
    sq_side_t   sq_last;
    ra_side_t   ra_in_side, ra_out_side;
    cordic_t    ra_a_in, ra_b_in, ra_a_out, ra_b_out;
    logic       ra_vld_out;
    logic [RA_SW-1:0] ra_side_bits;

    always_comb
    begin
        sq_last = sq_side[ROOT_W];
        ra_a_in = vec_prep($signed({{(CW-31){sq_last.d[15]}}, sq_last.d, 15'b0}),
                           $signed({{(CW-31){1'b0}}, sq_root[ROOT_W], 15'b0}));
        ra_b_in = vec_prep(sq_last.v0 >>> 2, sq_last.v1 >>> 2);
        ra_in_side.v2  = sq_last.v2;
        ra_in_side.f0  = sq_last.f0;
        ra_in_side.f1  = sq_last.f1;
        ra_in_side.f2  = sq_last.f2;
        ra_in_side.a   = sq_last.a;
        ra_in_side.lin = sq_last.lin;
    end

    uvs_cordic_row #(
        .N      (CORDIC_STAGES),
        .MODE_A (MODE_VEC),
        .MODE_B (MODE_VEC),
        .SW     (RA_SW)
    ) u_row_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (sq_vld[ROOT_W]),
        .a_in     (ra_a_in),
        .b_in     (ra_b_in),
        .side_in  (ra_in_side),
        .vld_out  (ra_vld_out),
        .a_out    (ra_a_out),
        .b_out    (ra_b_out),
        .side_out (ra_side_bits)
    );

    assign ra_out_side = ra_side_bits;

    // ---------------- stage 5: gain correction, scaled angle ----------------
    logic                 s5_vld_reg;
    logic signed [CW-1:0] s5_x2_reg, s5_x2_next;
    logic signed [CW-1:0] s5_th_reg, s5_th_next;
    logic signed [CW-1:0] s5_v2_reg;
    rb_side_t             s5_side_reg, s5_side_next;
    logic signed [65:0]   m1k;
    logic signed [53:0]   th_prod;

    always_comb
    begin
        m1k        = $signed(ra_b_out.x[32:0]) * $signed({2'b0, INVK});
        s5_x2_next = CW'((m1k + 66'sd536870912) >>> 30);
        th_prod    = 54'(ra_a_out.z) * 54'($signed({1'b0, ra_out_side.a}));
        s5_th_next = CW'(th_prod >>> 15);
        s5_side_next.f0  = ra_out_side.f0;
        s5_side_next.f1  = ra_out_side.f1;
        s5_side_next.f2  = ra_out_side.f2;
        s5_side_next.phi = ra_b_out.z;
        s5_side_next.lin = ra_out_side.lin;
    end

    // ---------------- row B: second vectoring, sin/cos of theta ----------------
    cordic_t          rb_a_in, rb_b_in, rb_a_out, rb_b_out;
    logic             rb_vld_out;
    logic [RB_SW-1:0] rb_side_bits;
    rb_side_t         rb_out_side;

    assign rb_a_in = vec_prep(s5_x2_reg, s5_v2_reg >>> 2);
    assign rb_b_in = rot_prep(s5_th_reg);

    uvs_cordic_row #(
        .N      (CORDIC_STAGES),
        .MODE_A (MODE_VEC),
        .MODE_B (MODE_ROT),
        .SW     (RB_SW)
    ) u_row_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (s5_vld_reg),
        .a_in     (rb_a_in),
        .b_in     (rb_b_in),
        .side_in  (s5_side_reg),
        .vld_out  (rb_vld_out),
        .a_out    (rb_a_out),
        .b_out    (rb_b_out),
        .side_out (rb_side_bits)
    );

    assign rb_out_side = rb_side_bits;

    // ---------------- stage 7: near-zero length test ----------------
    logic                 s7_vld_reg;
    logic signed [CW-1:0] s7_psi_reg;
    logic signed [CW-1:0] s7_phi_reg;
    rc_side_t             s7_side_reg, s7_side_next;
    logic signed [65:0]   m2k;
    logic signed [65:0]   m2s;

    always_comb
    begin
        m2k = $signed(rb_a_out.x[32:0]) * $signed({2'b0, INVK});
        m2s = (m2k + 66'sd536870912) >>> 30;
        s7_side_next.f0  = rb_out_side.f0;
        s7_side_next.f1  = rb_out_side.f1;
        s7_side_next.f2  = rb_out_side.f2;
        s7_side_next.c   = rb_b_out.x[31:0];
        s7_side_next.s   = rb_b_out.y[31:0];
        s7_side_next.nz  = m2s < 66'(NEAR_ZERO);
        s7_side_next.lin = rb_out_side.lin;
    end

    // ---------------- row C: sin/cos of psi and phi ----------------
    cordic_t          rc_a_in, rc_b_in, rc_a_out, rc_b_out;
    logic             rc_vld_out;
    logic [RC_SW-1:0] rc_side_bits;
    rc_side_t         rc_out_side;

    assign rc_a_in = rot_prep(s7_psi_reg);
    assign rc_b_in = rot_prep(s7_phi_reg);

    uvs_cordic_row #(
        .N      (CORDIC_STAGES),
        .MODE_A (MODE_ROT),
        .MODE_B (MODE_ROT),
        .SW     (RC_SW)
    ) u_row_c (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (s7_vld_reg),
        .a_in     (rc_a_in),
        .b_in     (rc_b_in),
        .side_in  (s7_side_reg),
        .vld_out  (rc_vld_out),
        .a_out    (rc_a_out),
        .b_out    (rc_b_out),
        .side_out (rc_side_bits)
    );

    assign rc_out_side = rc_side_bits;

    // ---------------- stage 9: unit vector ----------------
    logic               s9_vld_reg;
    logic signed [31:0] s9_u_reg [3];
    logic signed [31:0] s9_u_next [3];
    rc_side_t           s9_side_reg;
    logic signed [63:0] ux_prod, uy_prod;

    always_comb
    begin
        ux_prod = $signed(rc_a_out.x[31:0]) * $signed(rc_b_out.x[31:0]);
        uy_prod = $signed(rc_a_out.x[31:0]) * $signed(rc_b_out.y[31:0]);
        s9_u_next[0] = 32'((ux_prod + 64'sd536870912) >>> 30);
        s9_u_next[1] = 32'((uy_prod + 64'sd536870912) >>> 30);
        s9_u_next[2] = rc_a_out.y[31:0];
        if (rc_out_side.nz)
        begin
            for (int i = 0; i < 3; i++)
                s9_u_next[i] = '0;
        end
    end

    // ---------------- stage 10: output terms ----------------
    // linear: u*2^15 so the final Q.30 rounding gives u rounded to Q.15
    logic               s10_vld_reg;
    logic signed [49:0] s10_pf_reg [3];
    logic signed [49:0] s10_pu_reg [3];
    logic signed [49:0] s10_pf_next [3];
    logic signed [49:0] s10_pu_next [3];
    logic signed [63:0] us_prod [3];
    logic signed [15:0] fsel [3];

    always_comb
    begin
        fsel[0] = s9_side_reg.f0;
        fsel[1] = s9_side_reg.f1;
        fsel[2] = s9_side_reg.f2;
        for (int i = 0; i < 3; i++)
        begin
            us_prod[i] = 64'(s9_u_reg[i]) * 64'(s9_side_reg.s);
            if (s9_side_reg.lin)
            begin
                s10_pf_next[i] = $signed({{3{s9_u_reg[i][31]}}, s9_u_reg[i], 15'b0});
                s10_pu_next[i] = '0;
            end
            else
            begin
                s10_pf_next[i] = 50'(48'(fsel[i]) * 48'(s9_side_reg.c));
                s10_pu_next[i] = 50'((us_prod[i] + 64'sd16384) >>> 15);
            end
        end
    end

    // ---------------- stage 11: output register ----------------
    logic               out_valid_reg;
    out_t               out_data_reg, out_data_next;
    logic signed [49:0] acc [3];
    logic signed [19:0] res [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = s10_pf_reg[i] + s10_pu_reg[i];
            res[i] = 20'((acc[i] + 50'sd536870912) >>> 30);
        end
        out_data_next.out_x = sat16(res[0]);
        out_data_next.out_y = sat16(res[1]);
        out_data_next.out_z = sat16(res[2]);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg    <= 1'b0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s5_vld_reg    <= 1'b0;
            s7_vld_reg    <= 1'b0;
            s9_vld_reg    <= 1'b0;
            s10_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg    <= in_valid;
            s1_vld_reg    <= s0_vld_reg;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s5_vld_reg    <= ra_vld_out;
            s7_vld_reg    <= rb_vld_out;
            s9_vld_reg    <= rc_vld_out;
            s10_vld_reg   <= s9_vld_reg;
            out_valid_reg <= s10_vld_reg;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_f_reg[0] <= in_data.from_x;
            s0_f_reg[1] <= in_data.from_y;
            s0_f_reg[2] <= in_data.from_z;
            s0_t_reg[0] <= in_data.to_x;
            s0_t_reg[1] <= in_data.to_y;
            s0_t_reg[2] <= in_data.to_z;
            s0_a_reg    <= s0_a_next;

            for (int i = 0; i < 3; i++)
            begin
                s1_p_reg[i] <= 32'(s0_f_reg[i]) * 32'(s0_t_reg[i]);
                s1_f_reg[i] <= s0_f_reg[i];
                s1_t_reg[i] <= s0_t_reg[i];
                s2_f_reg[i] <= s1_f_reg[i];
                s2_t_reg[i] <= s1_t_reg[i];
            end
            s1_a_reg   <= s0_a_reg;
            s2_a_reg   <= s1_a_reg;
            s2_d_reg   <= s2_d_next;
            s2_lin_reg <= s2_lin_next;

            s3_rad_reg      <= s3_rad_next;
            s3_side_reg.v0  <= s3_v_next[0];
            s3_side_reg.v1  <= s3_v_next[1];
            s3_side_reg.v2  <= s3_v_next[2];
            s3_side_reg.f0  <= s2_f_reg[0];
            s3_side_reg.f1  <= s2_f_reg[1];
            s3_side_reg.f2  <= s2_f_reg[2];
            s3_side_reg.a   <= s2_a_reg;
            s3_side_reg.d   <= s2_d_reg[15:0];
            s3_side_reg.lin <= s2_lin_reg;

            s5_x2_reg   <= s5_x2_next;
            s5_th_reg   <= s5_th_next;
            s5_v2_reg   <= ra_out_side.v2;
            s5_side_reg <= s5_side_next;

            s7_psi_reg  <= rb_a_out.z;
            s7_phi_reg  <= rb_out_side.phi;
            s7_side_reg <= s7_side_next;

            s9_side_reg <= rc_out_side;
            for (int i = 0; i < 3; i++)
            begin
                s9_u_reg[i]   <= s9_u_next[i];
                s10_pf_reg[i] <= s10_pf_next[i];
                s10_pu_reg[i] <= s10_pu_next[i];
            end

            out_data_reg <= out_data_next;
        end
    end

    // ---------------- checks ----------------
    `UVS_ASSERT_NEXT(a_last_stage_reaches_out, en && s10_vld_reg, out_valid)
    `UVS_ASSERT_NEXT(a_cfg_write_lands, cfg_valid, thr_reg == $past(cfg_data))
    `UVS_ASSERT_IMP(a_root_is_floor, sq_vld[ROOT_W], sq_rem[ROOT_W] <= RAD_W'({sq_root[ROOT_W], 1'b0}))

endmodule

`default_nettype wire
